// File: hw/rtl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package pcxrle_pkg;

  // Width of the repeat count carried in a run header.
  localparam int unsigned COUNT_BITS = 6;

  // A byte with both top bits set opens a run.
  localparam logic [7:0] RUN_MARK = 8'hC0;

  // Widest pixel area of one scanline, in bytes.
  localparam logic [15:0] MAX_PIXEL_BYTES = 16'd8192;

  // Register reset values.
  localparam logic [15:0] LINE_BYTES_RST  = 16'd80;
  localparam logic [13:0] PIXEL_BYTES_RST = 14'd80;
  localparam logic [15:0] ROW_COUNT_RST   = 16'd480;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LINE_BYTES  = 2'd0,
    REG_PIXEL_BYTES = 2'd1,
    REG_ROW_COUNT   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the input item this cycle
    logic step;   // place one decoded byte this cycle
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;          // the offered item yields at least one placement
    logic last_place;  // the byte being placed is the last of the item
    logic slot_free;   // the output register can take a result
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/pcxrle_ctrl.sv
// Controller for the PCX run-length decoder: sequences item intake and placement.
// Depends on pcxrle_pkg for the command and status structs.
`default_nettype none

module pcxrle_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pcxrle_pkg::ctrl_sts_t sts,
  output pcxrle_pkg::ctrl_cmd_t      cmd
);

  import pcxrle_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  // Commands: take an item when not stalled, place one byte during a run when the output is free.
  always_comb begin
    cmd.load = in_valid && !in_stall_r;
    cmd.step = (state_r == ST_RUN) && sts.slot_free;
  end

  // Next state: a run stays until its last byte is placed.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load && sts.go) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.step && sts.last_place) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  // State and registered stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

  // An item with nothing to place leaves the controller ready for the next one.
  a_no_work_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !sts.go) |=> (state_r == ST_IDLE && !in_stall_r))
    else $error("controller left idle for an item with no placements");

  // The last placement of an item releases the input side.
  a_last_place_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last_place) |=> !in_stall_r)
    else $error("input still stalled after the last placement");

endmodule

`default_nettype wire

// File: hw/rtl/pcxrle_dpath.sv
// Datapath for the PCX run-length decoder: registers, line and row tracking,
// run count and the output register. Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_dpath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_wdata,
  input  wire logic [7:0]            in_byte,
  input  wire pcxrle_pkg::ctrl_cmd_t cmd,
  output pcxrle_pkg::ctrl_sts_t      sts,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_pixel_bits,
  output logic [15:0]                out_row_index,
  output logic [12:0]                out_byte_column,
  output logic                       out_last_of_run,
  output logic                       out_end_of_row,
  output logic                       out_end_of_image,
  output logic                       out_run_clipped
);

  import pcxrle_pkg::*;

  // Configuration registers.
  logic [15:0] line_bytes_r;
  logic [13:0] pixel_bytes_r;
  logic [15:0] row_count_r;

  // Decoder state.
  logic                  await_r;
  logic [COUNT_BITS-1:0] pend_r;
  logic [15:0]           pos_r;
  logic [15:0]           row_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [7:0]            val_r;
  logic                  clip_r;

  // Output register.
  logic        out_valid_r;
  logic [7:0]  out_pixel_bits_r;
  logic [15:0] out_row_index_r;
  logic [12:0] out_byte_column_r;
  logic        out_last_of_run_r;
  logic        out_end_of_row_r;
  logic        out_end_of_image_r;
  logic        out_run_clipped_r;

  // Effective line length, row count and pixel bytes per line.
  logic [15:0] eline, erows, pix_a, pix;
  always_comb begin
    eline = (line_bytes_r == 16'd0) ? 16'd1 : line_bytes_r;
    erows = (row_count_r == 16'd0) ? 16'd1 : row_count_r;
    pix_a = ({2'b00, pixel_bytes_r} > eline) ? eline : {2'b00, pixel_bytes_r};
    pix   = (pix_a > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : pix_a;
  end

  // Row advance with wrap after the last row.
  logic [16:0] row_inc;
  logic [15:0] row_adv;
  always_comb begin
    row_inc = {1'b0, row_r} + 17'd1;
    row_adv = (row_inc >= {1'b0, erows}) ? 16'd0 : row_inc[15:0];
  end

  // Intake: end a line that a shortened line length has left behind, then
  // work out how many bytes the item places.
  logic                  line_over, is_hdr, clip_n;
  logic [15:0]           pos_n, row_n, room;
  logic [COUNT_BITS-1:0] n_run;
  always_comb begin
    line_over = (pos_r >= eline);
    pos_n     = line_over ? 16'd0 : pos_r;
    row_n     = line_over ? row_adv : row_r;
    room      = eline - pos_n;
    clip_n    = ({{(16 - COUNT_BITS){1'b0}}, pend_r} > room);
    n_run     = clip_n ? room[COUNT_BITS-1:0] : pend_r;
    is_hdr    = ((in_byte & RUN_MARK) == RUN_MARK);
  end

  // Placement of one decoded byte at the current position.
  logic [16:0] pos_inc;
  logic        emit, eor, eoi, last_res;
  always_comb begin
    pos_inc  = {1'b0, pos_r} + 17'd1;
    emit     = (pos_r < pix);
    eor      = (pos_inc == {1'b0, pix});
    eoi      = eor && (row_inc == {1'b0, erows});
    last_res = (cnt_r == COUNT_BITS'(1)) || eor;
  end

  // Status to the controller.
  always_comb begin
    sts.go         = await_r ? (n_run != '0) : !is_hdr;
    sts.last_place = (cnt_r == COUNT_BITS'(1));
    sts.slot_free  = !out_valid_r || !out_stall;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r  <= LINE_BYTES_RST;
      pixel_bytes_r <= PIXEL_BYTES_RST;
      row_count_r   <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_LINE_BYTES:  line_bytes_r  <= cfg_wdata;
        REG_PIXEL_BYTES: pixel_bytes_r <= cfg_wdata[13:0];
        REG_ROW_COUNT:   row_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decoder state: intake loads it, each placement moves along the line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b0;
      pend_r  <= '0;
      pos_r   <= 16'd0;
      row_r   <= 16'd0;
      cnt_r   <= '0;
      clip_r  <= 1'b0;
    end else if (cmd.load) begin
      pos_r <= pos_n;
      row_r <= row_n;
      if (await_r) begin
        await_r <= 1'b0;
        pend_r  <= '0;
        cnt_r   <= n_run;
        clip_r  <= clip_n;
      end else if (is_hdr) begin
        await_r <= 1'b1;
        pend_r  <= in_byte[COUNT_BITS-1:0];
      end else begin
        cnt_r  <= COUNT_BITS'(1);
        clip_r <= 1'b0;
      end
    end else if (cmd.step) begin
      cnt_r <= cnt_r - COUNT_BITS'(1);
      if (pos_inc >= {1'b0, eline}) begin
        pos_r <= 16'd0;
        row_r <= row_adv;
      end else begin
        pos_r <= pos_inc[15:0];
      end
    end
  end

  // The byte value of the item.
  always_ff @(posedge clk) begin
    if (cmd.load) val_r <= in_byte;
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      out_pixel_bits_r   <= val_r;
      out_row_index_r    <= row_r;
      out_byte_column_r  <= pos_r[12:0];
      out_last_of_run_r  <= last_res;
      out_end_of_row_r   <= eor;
      out_end_of_image_r <= eoi;
      out_run_clipped_r  <= clip_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_bits   = out_pixel_bits_r;
  assign out_row_index    = out_row_index_r;
  assign out_byte_column  = out_byte_column_r;
  assign out_last_of_run  = out_last_of_run_r;
  assign out_end_of_row   = out_end_of_row_r;
  assign out_end_of_image = out_end_of_image_r;
  assign out_run_clipped  = out_run_clipped_r;

  // A placement always has bytes left to place.
  a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cnt_r != '0))
    else $error("placement with an empty count");

  // A pixel byte placed shows up in the output register.
  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && emit) |=> out_valid_r)
    else $error("pixel byte placed but no result presented");

  // A run header arms the wait for its value byte.
  a_header_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !await_r && is_hdr) |=> await_r)
    else $error("run header did not arm the value wait");

endmodule

`default_nettype wire

// File: hw/rtl/pcx_rle_scanline_decoder.sv
// PCX run-length scanline decoder, 1 bpp: top level joining controller and datapath.
// Flow: an item is taken into the datapath registers, the controller enters its run state,
// and each pixel byte placed is loaded into the output register. in_stall holds off the next
// item until its last byte is placed; one byte is placed per cycle while out_stall is low.
// Reset: rst_n is synchronous, active low; registers return to 80/80/480, state clears.
// Depends on pcxrle_pkg, pcxrle_ctrl and pcxrle_dpath.
`default_nettype none

module pcx_rle_scanline_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_pixel_bits,
  output logic [15:0]      out_row_index,
  output logic [12:0]      out_byte_column,
  output logic             out_last_of_run,
  output logic             out_end_of_row,
  output logic             out_end_of_image,
  output logic             out_run_clipped
);

  import pcxrle_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencing of intake and placement.
  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, line tracking and the output register.
  pcxrle_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_byte          (in_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_bits   (out_pixel_bits),
    .out_row_index    (out_row_index),
    .out_byte_column  (out_byte_column),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_image (out_end_of_image),
    .out_run_clipped  (out_run_clipped)
  );

endmodule

`default_nettype wire
